@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assertion macros
// concurrent assertion helpers used by the top-level rtl file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// cond must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("assertion failed: forbidden condition seen");

// ante implies cons in the same cycle
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");

`else

`define ASSERT_NEVER(label, clk, rst, cond)
`define ASSERT_IMPLY(label, clk, rst, ante, cons)

`endif

`endif

@@ design/olm_pkg.sv @@
// ---------------------------------------------------------------------------
// olm_pkg
// types and constants of the occupancy light mode controller
// ---------------------------------------------------------------------------
`default_nettype none

package olm_pkg;

  localparam logic [7:0] BUS_BCAST = 8'hFF;
  localparam logic [7:0] CMD_OFF   = 8'h00;
  localparam logic [7:0] CMD_UP    = 8'h01;
  localparam logic [7:0] CMD_DOWN  = 8'h02;
  localparam logic [7:0] CMD_SC1   = 8'h11;
  localparam logic [7:0] CMD_SC2   = 8'h12;
  localparam logic [7:0] CMD_SC3   = 8'h13;

  localparam logic [3:0] STEP_MAX  = 4'd10;

  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_NORMAL  = 2'd1;
  localparam logic [1:0] MODE_STANDBY = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_NORMAL_HOLD  = 3'd0;
  localparam logic [2:0] REG_STANDBY_HOLD = 3'd1;
  localparam logic [2:0] REG_TICK         = 3'd2;
  localparam logic [2:0] REG_NORMAL_STEP  = 3'd3;
  localparam logic [2:0] REG_STANDBY_STEP = 3'd4;

  localparam int MAX_RESULTS = 4;

  typedef struct packed {
    logic [31:0] normal_hold;
    logic [31:0] standby_hold;
    logic [9:0]  tick_ms;
    logic [3:0]  normal_level;
    logic [3:0]  standby_level;
  } cfg_t;

  // one result as it leaves the block
  typedef struct packed {
    logic       frame_valid;
    logic [7:0] cmd;
    logic       relay;
    logic [1:0] mode;
    logic [3:0] step;
  } entry_t;

  // all results of one tick
  typedef struct packed {
    entry_t [MAX_RESULTS-1:0] ent;
    logic [1:0]               n_last;
  } rec_t;

  function automatic logic [3:0] sat_step(input logic [3:0] s);
    sat_step = (s > STEP_MAX) ? STEP_MAX : s;
  endfunction

endpackage

`default_nettype wire

@@ design/olm_front.sv @@
// ---------------------------------------------------------------------------
// olm_front
// takes ticks, updates mode, countdowns, step and relay, and builds the
// list of results of the tick
// ---------------------------------------------------------------------------
`default_nettype none

module olm_front
  import olm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire logic in_valid,
  input  wire logic in_ready,
  input  wire logic up,
  input  wire logic down,
  input  wire logic trig,
  input  wire logic active,
  output logic      push,
  output rec_t      rec
);

  logic [1:0]  mode;
  logic [31:0] normal_left;
  logic [31:0] standby_left;
  logic [3:0]  step;
  logic        relay;

  logic [1:0]  mode_next;
  logic [31:0] normal_left_next;
  logic [31:0] standby_left_next;
  logic [3:0]  step_next;
  logic        relay_next;

  logic        up_ok, down_ok, enter, in_normal;
  logic [3:0]  s1, s2, s3;
  logic        r3;
  logic [1:0]  m3;
  logic [31:0] nl3, sl3, cnt_sel, cnt_dec;
  logic        expire_n, expire_s;
  entry_t      cand [5];
  logic [4:0]  cand_en;
  logic [2:0]  k;
  entry_t      status;

  assign push = in_valid && in_ready;

  always_comb begin
    in_normal = (mode == MODE_NORMAL);
    up_ok     = up && in_normal && (step < STEP_MAX);
    s1        = up_ok ? step + 4'd1 : step;
    down_ok   = down && in_normal && (s1 != 4'd0);
    s2        = down_ok ? s1 - 4'd1 : s1;
    enter     = trig || (active && !in_normal);
    m3        = enter ? MODE_NORMAL : mode;
    r3        = enter ? 1'b1 : relay;
    s3        = enter ? sat_step(cfg.normal_level) : s2;
    nl3       = (enter || (active && in_normal)) ? cfg.normal_hold : normal_left;
    sl3       = enter ? 32'd0 : standby_left;

    // one shared countdown step for whichever mode is running
    cnt_sel   = (m3 == MODE_NORMAL) ? nl3 : sl3;
    cnt_dec   = (cnt_sel >= {22'd0, cfg.tick_ms}) ? cnt_sel - {22'd0, cfg.tick_ms} : 32'd0;
    expire_n  = (m3 == MODE_NORMAL) && (cnt_dec == 32'd0);
    expire_s  = (m3 == MODE_STANDBY) && (cnt_dec == 32'd0);

    mode_next         = m3;
    normal_left_next  = nl3;
    standby_left_next = sl3;
    step_next         = s3;
    relay_next        = r3;
    if (m3 == MODE_NORMAL) begin
      normal_left_next = cnt_dec;
      if (expire_n) begin
        mode_next         = MODE_STANDBY;
        standby_left_next = cfg.standby_hold;
        relay_next        = 1'b1;
        step_next         = sat_step(cfg.standby_level);
      end
    end else if (m3 == MODE_STANDBY) begin
      standby_left_next = cnt_dec;
      if (expire_s) begin
        mode_next        = MODE_OFF;
        normal_left_next = 32'd0;
        step_next        = 4'd0;
        relay_next       = 1'b0;
      end
    end

    // candidate results in tick order, each with the state seen at that point
    cand[0]    = '{frame_valid: 1'b1, cmd: CMD_UP,   relay: relay, mode: mode, step: s1};
    cand[1]    = '{frame_valid: 1'b1, cmd: CMD_DOWN, relay: relay, mode: mode, step: s2};
    cand[2]    = '{frame_valid: 1'b1, cmd: CMD_SC3,  relay: 1'b1, mode: MODE_NORMAL, step: s3};
    cand[3]    = expire_n ?
                 '{frame_valid: 1'b1, cmd: CMD_SC2, relay: 1'b1, mode: MODE_STANDBY,
                   step: sat_step(cfg.standby_level)} :
                 '{frame_valid: 1'b1, cmd: CMD_SC1, relay: r3, mode: MODE_OFF, step: 4'd0};
    cand[4]    = '{frame_valid: 1'b1, cmd: CMD_OFF, relay: 1'b0, mode: MODE_OFF, step: 4'd0};
    cand_en    = {expire_s, expire_n || expire_s, enter, down_ok, up_ok};

    status     = '{frame_valid: 1'b0, cmd: CMD_OFF, relay: relay_next, mode: mode_next,
                   step: step_next};

    // compact the enabled candidates, at most four can be set together
    rec = '0;
    k   = 3'd0;
    for (int i = 0; i < 5; i++) begin
      if (cand_en[i]) begin
        rec.ent[k[1:0]] = cand[i];
        k = k + 3'd1;
      end
    end
    if (k == 3'd0) begin
      rec.ent[0] = status;
      rec.n_last = 2'd0;
    end else begin
      rec.n_last = 2'(k - 3'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_OFF;
      normal_left  <= 32'd0;
      standby_left <= 32'd0;
      step         <= 4'd0;
      relay        <= 1'b0;
    end else if (push) begin
      mode         <= mode_next;
      normal_left  <= normal_left_next;
      standby_left <= standby_left_next;
      step         <= step_next;
      relay        <= relay_next;
    end
  end

endmodule

`default_nettype wire

@@ design/olm_queue.sv @@
// ---------------------------------------------------------------------------
// olm_queue
// small register queue of per-tick result lists between front and back
// ---------------------------------------------------------------------------
`default_nettype none

module olm_queue
  import olm_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire rec_t wr_rec,
  output logic      not_full,
  input  wire logic pop,
  output logic      not_empty,
  output rec_t      rd_rec
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rec_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign not_full  = (count != CW'(DEPTH));
  assign not_empty = (count != '0);
  assign rd_rec    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ design/olm_back.sv @@
// ---------------------------------------------------------------------------
// olm_back
// walks the result list of the head tick and drives the output register
// ---------------------------------------------------------------------------
`default_nettype none

module olm_back
  import olm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire rec_t q_rec,
  output logic      pop,
  output logic      out_valid,
  input  wire logic out_ready,
  output entry_t    out_ent,
  output logic      out_last
);

  logic [1:0] idx;
  logic       load;
  logic       at_last;

  assign load    = q_valid && (!out_valid || out_ready);
  assign at_last = (idx == q_rec.n_last);
  assign pop     = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_last ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ent  <= q_rec.ent[idx];
      out_last <= at_last;
    end
  end

endmodule

`default_nettype wire

@@ design/occupancy_light_mode_controller.sv @@
// ---------------------------------------------------------------------------
// occupancy light mode controller
// per-tick mode, countdown, brightness and relay control that emits
// broadcast lighting frames and status results
// ---------------------------------------------------------------------------
//
// channel   dir  handshake                 payload
// s_*       in   s_tvalid / s_tready       one service tick (button and motion flags)
// m_*       out  m_tvalid / m_tready       one result, m_tlast on the last of a tick
// apb       in   psel, penable, pwrite     five config registers at 4*i
//
// a tick is taken whenever the queue has room; its whole state
// update happens at that edge in the front part
// the back part sends one result per cycle while m_tready allows, so a tick with
// n results gives max(1, n) transactions (at most 4); the output register sets this
// the queue holds QUEUE_DEPTH finished ticks, so input and output stall apart
// synchronous active-high reset; mode off, counters, step and relay zero,
// config registers back to their defaults; reset emits nothing
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module occupancy_light_mode_controller
  import olm_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // tick input
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // btn_up, btn_down, motion_trig,
                                      // motion_act, pad
  // result output
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // frame_address[7:0], frame_data[15:8],
                                      // relay[16], light_mode[18:17],
                                      // bright_step[22:19], pad
  output logic [0:0]       m_tuser,   // frame_valid
  output logic             m_tlast,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  cfg_t       cfg;
  logic       cfg_wr;
  logic [2:0] reg_idx;

  logic       push;
  rec_t       wr_rec;
  logic       q_not_empty;
  rec_t       q_rec;
  logic       pop;
  entry_t     out_ent;
  logic       out_last;
  logic       off_frame;

  // config registers
  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.normal_hold   <= 32'd300000;
      cfg.standby_hold  <= 32'd1200000;
      cfg.tick_ms       <= 10'd5;
      cfg.normal_level  <= 4'd9;
      cfg.standby_level <= 4'd2;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_NORMAL_HOLD:  cfg.normal_hold   <= pwdata;
        REG_STANDBY_HOLD: cfg.standby_hold  <= pwdata;
        REG_TICK:         cfg.tick_ms       <= pwdata[9:0];
        REG_NORMAL_STEP:  cfg.normal_level  <= pwdata[3:0];
        REG_STANDBY_STEP: cfg.standby_level <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NORMAL_HOLD:  prdata = cfg.normal_hold;
      REG_STANDBY_HOLD: prdata = cfg.standby_hold;
      REG_TICK:         prdata = {22'd0, cfg.tick_ms};
      REG_NORMAL_STEP:  prdata = {28'd0, cfg.normal_level};
      REG_STANDBY_STEP: prdata = {28'd0, cfg.standby_level};
      default:          prdata = 32'd0;
    endcase
  end

  // front: classifies the tick and updates state at acceptance
  olm_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .up       (s_tdata[0]),
    .down     (s_tdata[1]),
    .trig     (s_tdata[2]),
    .active   (s_tdata[3]),
    .push     (push),
    .rec      (wr_rec)
  );

  // queue of finished result lists
  olm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_rec    (wr_rec),
    .not_full  (s_tready),
    .pop       (pop),
    .not_empty (q_not_empty),
    .rd_rec    (q_rec)
  );

  // back: one result per cycle into the output register while m_tready allows
  olm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_not_empty),
    .q_rec     (q_rec),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_ent   (out_ent),
    .out_last  (out_last)
  );

  // status results carry zero address and data
  assign m_tdata = {1'b0, out_ent.step, out_ent.mode, out_ent.relay,
                    out_ent.frame_valid ? out_ent.cmd : CMD_OFF,
                    out_ent.frame_valid ? BUS_BCAST : 8'd0};
  assign m_tuser = out_ent.frame_valid;
  assign m_tlast = out_last;

  assign off_frame = m_tvalid && out_ent.frame_valid && (out_ent.cmd == CMD_OFF);

  // normal mode always has the driver supply on
  `ASSERT_IMPLY(a_normal_relay, clk, rst, m_tvalid && (out_ent.mode == MODE_NORMAL), out_ent.relay)
  // brightness step stays within range
  `ASSERT_NEVER(a_step_range, clk, rst, m_tvalid && (out_ent.step > STEP_MAX))
  // a status result is the only result of its tick
  `ASSERT_IMPLY(a_status_last, clk, rst, m_tvalid && !out_ent.frame_valid, out_last)
  // the off frame closes its tick with the relay dropped
  `ASSERT_IMPLY(a_off_last, clk, rst, off_frame, out_last && !out_ent.relay)

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// ---------------------------------------------------------------------------
// tb_top
// checks the occupancy light mode controller transaction by transaction: a
// behavioral copy of mode, countdown, step and relay logic predicts the frames
// and status results of every accepted tick, and each output transaction is
// compared field by field with the oldest prediction. directed ticks cover the
// step limits, zero holds, zero tick and the four-frame tick; random ticks run
// under several register settings, most of them with random stalls on both streams
// ---------------------------------------------------------------------------
`default_nettype none

import olm_pkg::*;

// input flags of one tick, up button in bit 0
typedef struct packed {
  logic active;
  logic trig;
  logic down;
  logic up;
} tick_t;

// one predicted output transaction
typedef struct packed {
  logic       fv;
  logic [7:0] addr;
  logic [7:0] cmd;
  logic       relay;
  logic [1:0] mode;
  logic [3:0] step;
  logic       last;
} frame_t;

class light_frame_checker;
  logic [31:0] normal_hold, standby_hold;
  logic [9:0]  tick_len;
  logic [3:0]  normal_lvl, standby_lvl;
  logic [1:0]  mode;
  logic [31:0] normal_left, standby_left;
  logic [3:0]  step;
  logic        relay;
  frame_t      frames_due[$];
  frame_t      held;
  bit          have_held;
  int          errors;

  function new();
    normal_hold  = 32'd300000;
    standby_hold = 32'd1200000;
    tick_len     = 10'd5;
    normal_lvl   = 4'd9;
    standby_lvl  = 4'd2;
    mode         = MODE_OFF;
    normal_left  = '0;
    standby_left = '0;
    step         = '0;
    relay        = 1'b0;
    have_held    = 0;
    errors       = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] v);
    case (idx)
      REG_NORMAL_HOLD:  normal_hold  = v;
      REG_STANDBY_HOLD: standby_hold = v;
      REG_TICK:         tick_len     = v[9:0];
      REG_NORMAL_STEP:  normal_lvl   = v[3:0];
      REG_STANDBY_STEP: standby_lvl  = v[3:0];
      default: ;
    endcase
  endfunction

  function int pending();
    return frames_due.size();
  endfunction

  function logic [3:0] clip(logic [3:0] s);
    return (s > STEP_MAX) ? STEP_MAX : s;
  endfunction

  function logic [31:0] drain(logic [31:0] left);
    return (left >= {22'd0, tick_len}) ? left - {22'd0, tick_len} : 32'd0;
  endfunction

  // holds back one result so the final one of a tick can get its last flag
  function void emit(logic fv, logic [7:0] cmd);
    if (have_held) frames_due.push_back(held);
    held = {fv, fv ? BUS_BCAST : 8'h00, fv ? cmd : 8'h00, relay, mode, step, 1'b0};
    have_held = 1;
  endfunction

  function void note_tick(tick_t f);
    if (f.up && mode == MODE_NORMAL && step < STEP_MAX) begin
      step = step + 4'd1;
      emit(1'b1, CMD_UP);
    end
    if (f.down && mode == MODE_NORMAL && step != 4'd0) begin
      step = step - 4'd1;
      emit(1'b1, CMD_DOWN);
    end
    if (f.trig || (f.active && mode != MODE_NORMAL)) begin
      mode         = MODE_NORMAL;
      standby_left = '0;
      relay        = 1'b1;
      step         = clip(normal_lvl);
      normal_left  = normal_hold;
      emit(1'b1, CMD_SC3);
    end else if (f.active) begin
      normal_left = normal_hold;
    end
    if (mode == MODE_NORMAL) begin
      normal_left = drain(normal_left);
      if (normal_left == 32'd0) begin
        mode         = MODE_STANDBY;
        standby_left = standby_hold;
        relay        = 1'b1;
        step         = clip(standby_lvl);
        emit(1'b1, CMD_SC2);
      end
    end else if (mode == MODE_STANDBY) begin
      standby_left = drain(standby_left);
      if (standby_left == 32'd0) begin
        mode        = MODE_OFF;
        normal_left = '0;
        step        = '0;
        emit(1'b1, CMD_SC1);
        relay = 1'b0;
        emit(1'b1, CMD_OFF);
      end
    end
    if (!have_held) emit(1'b0, CMD_OFF);
    held.last = 1'b1;
    frames_due.push_back(held);
    have_held = 0;
  endfunction

  function void agree(string what, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t mismatch %s: expected %0h actual %0h", $time, what, want, got);
      errors++;
    end
  endfunction

  function void check_frame(logic [23:0] tdata, logic tuser, logic tlast);
    frame_t exp_f;
    if (frames_due.size() == 0) begin
      $display("%0t unexpected result: expected none actual %h/%b/%b",
               $time, tdata, tuser, tlast);
      errors++;
      return;
    end
    exp_f = frames_due.pop_front();
    agree("frame_valid", exp_f.fv, tuser);
    agree("frame_address", exp_f.addr, tdata[7:0]);
    agree("frame_data", exp_f.cmd, tdata[15:8]);
    agree("relay", exp_f.relay, tdata[16]);
    agree("light_mode", exp_f.mode, tdata[18:17]);
    agree("bright_step", exp_f.step, tdata[22:19]);
    agree("last", exp_f.last, tlast);
  endfunction
endclass

module tb_top;

  localparam int LIMIT = 300000;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [4:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  light_frame_checker book = new();

  int stall_pct  = 0;   // chance of a receiver stall burst, percent
  int stall_left = 0;
  int cycles     = 0;

  occupancy_light_mode_controller dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog, counts every cycle of the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // result monitor, samples the output transaction at the rising edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) book.check_frame(m_tdata, m_tuser[0], m_tlast);
  end

  // receiver back-pressure in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left <= $urandom_range(0, 13);
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // apb write: setup cycle, then access cycle; psel stays up for a following write
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= v;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    book.set_reg(idx, v);
    @(negedge clk);
  endtask

  task automatic program_regs(input logic [31:0] nh, input logic [31:0] sh,
                              input logic [9:0] tk, input logic [3:0] ns,
                              input logic [3:0] ss);
    write_reg(REG_NORMAL_HOLD, nh);
    write_reg(REG_STANDBY_HOLD, sh);
    write_reg(REG_TICK, {22'd0, tk});
    write_reg(REG_NORMAL_STEP, {28'd0, ns});
    write_reg(REG_STANDBY_STEP, {28'd0, ss});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one tick transaction; tvalid is left high for a following tick
  task automatic send_tick(input tick_t f);
    s_tdata  <= {4'b0000, f};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    book.note_tick(f);
    @(negedge clk);
  endtask

  // drop tvalid and let every outstanding result drain
  task automatic settle();
    s_tvalid <= 1'b0;
    while (book.pending() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_hold();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 60);
    endcase
  endfunction

  function automatic logic [9:0] pick_tick();
    case ($urandom_range(0, 9))
      0: return 10'd0;
      1: return 10'd1023;
      2: return 10'd1000;
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  initial begin
    int    ph;
    int    k;
    int    gap_pct;
    tick_t f;

    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: reset settings, buttons while off, entering normal, step limits
    send_tick(4'b0000);
    send_tick(4'b0011);   // buttons ignored while off
    send_tick(4'b1000);   // presence enters normal
    send_tick(4'b0001);   // up to the top step
    send_tick(4'b0001);   // top step saturates, status only
    send_tick(4'b1010);   // down plus hold refresh
    send_tick(4'b1111);
    settle();

    // zero normal hold, step registers above ten saturate
    program_regs(32'd0, 32'd12, 10'd5, 4'd15, 4'd11);
    send_tick(4'b0111);   // up, down, scene 3 and scene 2 in one tick
    send_tick(4'b0000);
    send_tick(4'b0000);
    send_tick(4'b0000);   // standby runs out, scene 1 then off
    send_tick(4'b0001);
    settle();

    // zero tick: a counter at zero still expires, others stay put
    program_regs(32'd0, 32'd3, 10'd0, 4'd4, 4'd1);
    send_tick(4'b0100);
    send_tick(4'b0000);
    send_tick(4'b1000);   // presence in standby goes back to normal
    settle();

    // largest holds and tick, step limits of the other end
    program_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 10'd1023, 4'd0, 4'd10);
    send_tick(4'b0100);
    send_tick(4'b0010);   // bottom step, status only
    send_tick(4'b0001);
    send_tick(4'b1000);
    send_tick(4'b0100);
    settle();

    // random phases, each under its own register setting
    for (ph = 0; ph < 6; ph++) begin
      program_regs(pick_hold(), pick_hold(), pick_tick(),
                   $urandom_range(0, 15), $urandom_range(0, 15));
      // phase 2 runs without stalls, the final phase runs flat out
      gap_pct   = (ph == 2 || ph == 5) ? 0 : 25;
      stall_pct = (ph == 2 || ph == 5) ? 0 : 20;
      for (k = 0; k < 50; k++) begin
        f.up     = ($urandom_range(0, 99) < 40);
        f.down   = ($urandom_range(0, 99) < 40);
        f.trig   = ($urandom_range(0, 99) < 12);
        f.active = ($urandom_range(0, 99) < 30);
        send_tick(f);
        if ($urandom_range(0, 99) < gap_pct) begin
          s_tvalid <= 1'b0;
          repeat ($urandom_range(1, 14)) @(negedge clk);
        end
      end
      settle();
    end

    // final wait to catch stray results, then report
    repeat (20) @(negedge clk);
    if (book.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ occupancy_light_mode_controller.f @@
+incdir+design
design/olm_pkg.sv
design/olm_front.sv
design/olm_queue.sv
design/olm_back.sv
design/occupancy_light_mode_controller.sv
test/tb_top.sv
